>>> sv/watch_time_set_controller_defines.svh
// ----------------------------------------------------------------------------
// Watch time-set controller assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef WATCH_TIME_SET_CONTROLLER_DEFINES_SVH
`define WATCH_TIME_SET_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define WTSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtsc: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define WTSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wtsc: next-cycle check failed");

`endif

>>> sv/wtsc_pkg.sv
// ----------------------------------------------------------------------------
// Watch time-set controller package
// Types, codes and helper functions shared by the controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wtsc_pkg;

  // Controller state, one-hot
  typedef enum logic [2:0] {
    ST_SHOW = 3'b001,
    ST_SET  = 3'b010,
    ST_END  = 3'b100
  } state_t;

  // Mode codes as presented on the result word
  localparam logic [1:0] MODE_SHOW = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // Event kinds
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_KEY   = 3'd1;
  localparam logic [2:0] CMD_UP    = 3'd2;
  localparam logic [2:0] CMD_DOWN  = 3'd3;
  localparam logic [2:0] CMD_LEFT  = 3'd4;
  localparam logic [2:0] CMD_RIGHT = 3'd5;

  localparam logic [7:0] QUIT_KEY    = 8'd120;  // 'x'
  localparam logic [6:0] HOUR_LIMIT  = 7'd24;
  localparam logic [6:0] SIXTY_LIMIT = 7'd60;
  localparam logic [6:0] STEP_TENS   = 7'd10;
  localparam logic [6:0] STEP_ONES   = 7'd1;
  localparam logic [2:0] LAST_POS    = 3'd6;

  // One input event
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] key_code;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } event_t;

  // One result word
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] cursor;
    logic [3:0] cursor_column;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic [5:0] shown_second;
    logic       commit;
  } result_t;

  // Controller registers
  typedef struct packed {
    state_t     state;
    logic [2:0] cursor;
    logic [4:0] edit_hour;
    logic [5:0] edit_minute;
    logic [5:0] edit_second;
  } ctrl_t;

  // Display column of each cursor position
  function automatic logic [3:0] cursor_col(input logic [2:0] pos);
    logic [3:0] col;
    case (pos)
      3'd0:    col = 4'd0;
      3'd1:    col = 4'd4;
      3'd2:    col = 4'd5;
      3'd3:    col = 4'd7;
      3'd4:    col = 4'd8;
      3'd5:    col = 4'd10;
      3'd6:    col = 4'd11;
      default: col = 4'd11;
    endcase
    return col;
  endfunction

  // Bump a field up or down by one digit step; drop a bump that leaves range
  function automatic logic [5:0] bump(input logic [5:0] val, input logic up,
                                      input logic [6:0] step, input logic [6:0] limit);
    logic [6:0] sum;
    logic [5:0] res;
    sum = {1'b0, val} + step;
    if (up) begin
      res = (sum < limit) ? sum[5:0] : val;
    end else begin
      res = ({1'b0, val} >= step) ? (val - step[5:0]) : val;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/wtsc_step.sv
// ----------------------------------------------------------------------------
// Watch time-set controller event step
// Next controller registers and the result word for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsc_step (
  input  wtsc_pkg::event_t  evt,
  input  wtsc_pkg::ctrl_t   cur,
  output wtsc_pkg::ctrl_t   nxt,
  output wtsc_pkg::result_t res
);

  logic       up;
  logic [5:0] hour_tens;
  logic [5:0] hour_ones;
  logic [5:0] min_tens;
  logic [5:0] min_ones;
  logic [5:0] sec_tens;
  logic [5:0] sec_ones;
  logic       did_commit;
  logic       show_edit;

  // Candidate digit bumps for every field
  assign up        = (evt.command == wtsc_pkg::CMD_UP);
  assign hour_tens = wtsc_pkg::bump({1'b0, cur.edit_hour}, up, wtsc_pkg::STEP_TENS,
                                    wtsc_pkg::HOUR_LIMIT);
  assign hour_ones = wtsc_pkg::bump({1'b0, cur.edit_hour}, up, wtsc_pkg::STEP_ONES,
                                    wtsc_pkg::HOUR_LIMIT);
  assign min_tens  = wtsc_pkg::bump(cur.edit_minute, up, wtsc_pkg::STEP_TENS,
                                    wtsc_pkg::SIXTY_LIMIT);
  assign min_ones  = wtsc_pkg::bump(cur.edit_minute, up, wtsc_pkg::STEP_ONES,
                                    wtsc_pkg::SIXTY_LIMIT);
  assign sec_tens  = wtsc_pkg::bump(cur.edit_second, up, wtsc_pkg::STEP_TENS,
                                    wtsc_pkg::SIXTY_LIMIT);
  assign sec_ones  = wtsc_pkg::bump(cur.edit_second, up, wtsc_pkg::STEP_ONES,
                                    wtsc_pkg::SIXTY_LIMIT);

  // Advance the mode, cursor and edited time
  always_comb begin
    nxt        = cur;
    did_commit = 1'b0;
    case (cur.state)
      wtsc_pkg::ST_SHOW: begin
        if (evt.command == wtsc_pkg::CMD_UP || evt.command == wtsc_pkg::CMD_DOWN) begin
          nxt.edit_hour   = evt.now_hour;
          nxt.edit_minute = evt.now_minute;
          nxt.edit_second = evt.now_second;
          nxt.state       = wtsc_pkg::ST_SET;
        end else if (evt.command == wtsc_pkg::CMD_LEFT) begin
          if (cur.cursor == 3'd0) nxt.state = wtsc_pkg::ST_END;
        end else if (evt.command == wtsc_pkg::CMD_KEY) begin
          if (evt.key_code == wtsc_pkg::QUIT_KEY) nxt.state = wtsc_pkg::ST_END;
        end
      end
      wtsc_pkg::ST_SET: begin
        if (evt.command == wtsc_pkg::CMD_LEFT) begin
          if (cur.cursor != 3'd0) nxt.cursor = cur.cursor - 3'd1;
        end else if (evt.command == wtsc_pkg::CMD_RIGHT) begin
          if (cur.cursor < wtsc_pkg::LAST_POS) begin
            nxt.cursor = cur.cursor + 3'd1;
          end else begin
            nxt.cursor = 3'd0;
            did_commit = 1'b1;
            nxt.state  = wtsc_pkg::ST_SHOW;
          end
        end else if (evt.command == wtsc_pkg::CMD_UP ||
                     evt.command == wtsc_pkg::CMD_DOWN) begin
          case (cur.cursor)
            3'd1:    nxt.edit_hour   = hour_tens[4:0];
            3'd2:    nxt.edit_hour   = hour_ones[4:0];
            3'd3:    nxt.edit_minute = min_tens;
            3'd4:    nxt.edit_minute = min_ones;
            3'd5:    nxt.edit_second = sec_tens;
            3'd6:    nxt.edit_second = sec_ones;
            default: nxt.state       = wtsc_pkg::ST_SHOW;
          endcase
        end else if (evt.command == wtsc_pkg::CMD_KEY) begin
          if (evt.key_code == wtsc_pkg::QUIT_KEY) nxt.state = wtsc_pkg::ST_END;
        end
      end
      default: begin
        // ended: hold everything
      end
    endcase
  end

  // Build the result word from the new registers
  assign show_edit = (nxt.state == wtsc_pkg::ST_SET) || did_commit;

  always_comb begin
    case (nxt.state)
      wtsc_pkg::ST_SHOW: res.mode = wtsc_pkg::MODE_SHOW;
      wtsc_pkg::ST_SET:  res.mode = wtsc_pkg::MODE_SET;
      default:           res.mode = wtsc_pkg::MODE_END;
    endcase
    res.cursor        = nxt.cursor;
    res.cursor_column = wtsc_pkg::cursor_col(nxt.cursor);
    res.shown_hour    = show_edit ? nxt.edit_hour   : evt.now_hour;
    res.shown_minute  = show_edit ? nxt.edit_minute : evt.now_minute;
    res.shown_second  = show_edit ? nxt.edit_second : evt.now_second;
    res.commit        = did_commit;
  end

endmodule

`default_nettype wire

>>> sv/watch_time_set_controller.sv
// ----------------------------------------------------------------------------
// Watch time-set controller
// Key-driven time setting for a watch: mode, cursor and edited time.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one key event per word: the event kind on
//   s_tuser and the key code with the current hour, minute and second on
//   s_tdata. The master channel returns one result word per event: mode,
//   cursor, cursor column and shown time on m_tdata, the commit flag on
//   m_tuser. When commit is set the shown time is to be written into the
//   system clock.
//   An accepted event sits in the input register; when the result register
//   is free or being taken, the event logic updates the controller registers
//   and loads the result register. Throughput is one event per cycle while
//   the receiver takes each result, as the mode, cursor and edit registers
//   update together for each event.
//   Reset puts the controller in show-time mode with the cursor at position
//   zero and empties both registers. When the receiver stalls, the result
//   holds, one further event waits in the input register, and s_tready then
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "watch_time_set_controller_defines.svh"

module watch_time_set_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key_code, now_hour, now_minute, now_second, zero fill
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // mode, cursor, cursor_column, shown_hour,
                                 // shown_minute, shown_second, zero fill
  output logic        m_tuser    // commit
);

  logic              in_valid;
  wtsc_pkg::event_t  in_evt;
  logic              out_valid;
  wtsc_pkg::result_t out_res;
  wtsc_pkg::ctrl_t   ctrl;
  wtsc_pkg::ctrl_t   ctrl_next;
  wtsc_pkg::result_t res_next;
  logic              s_accept;
  logic              advance;

  // Handshake between input register and result register
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign s_tready = !in_valid || advance;

  // Hold the accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_evt.command    <= s_tuser;
      in_evt.key_code   <= s_tdata[7:0];
      in_evt.now_hour   <= s_tdata[12:8];
      in_evt.now_minute <= s_tdata[18:13];
      in_evt.now_second <= s_tdata[24:19];
    end
  end

  // Event logic
  wtsc_step u_step (
    .evt (in_evt),
    .cur (ctrl),
    .nxt (ctrl_next),
    .res (res_next)
  );

  // Advance the controller registers; the edited time needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.state  <= wtsc_pkg::ST_SHOW;
      ctrl.cursor <= 3'd0;
    end else if (advance) begin
      ctrl <= ctrl_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.shown_second, out_res.shown_minute, out_res.shown_hour,
                     out_res.cursor_column, out_res.cursor, out_res.mode};
  assign m_tuser  = out_res.commit;

  // Assertions
  `WTSC_ASSERT_IMPLY(a_commit_home, clk, rst, out_valid && out_res.commit,
    out_res.mode == wtsc_pkg::MODE_SHOW && out_res.cursor == 3'd0)
  `WTSC_ASSERT_NEXT(a_end_sticks, clk, rst, ctrl.state == wtsc_pkg::ST_END,
    ctrl.state == wtsc_pkg::ST_END)
  `WTSC_ASSERT_IMPLY(a_cursor_range, clk, rst, 1'b1, ctrl.cursor <= wtsc_pkg::LAST_POS)
  `WTSC_ASSERT_NEXT(a_event_waits, clk, rst, in_valid && out_valid && !m_tready,
    in_valid && out_valid)

endmodule

`default_nettype wire
